/* hw/rtl/orwm_pkg.sv */
// ----------------------------------------------------------------------------
// orwm_pkg
// shared constants, codes and types of the oversampled ratio window monitor
// ----------------------------------------------------------------------------
package orwm_pkg;

  localparam int DEF_CHANNELS = 6;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 21;
  localparam int COUNT_W      = 8;
  localparam int LIMIT_W      = 16;
  localparam int RATIO_W      = 16;
  localparam int FAULT_W      = 12;
  localparam int RATIO_OUTS   = 5;
  localparam int RIDX_W       = 3;
  localparam int DVD_W        = 25;
  localparam int DVS_W        = 21;
  localparam int Q_DEPTH      = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX       = 16'd5000;
  localparam logic [DVD_W-1:0]    SCALE            = 25'd12;
  localparam logic [FAULT_W-1:0]  FAULT_BASE       = 12'hE00;
  localparam logic [RATIO_W-1:0]  RATIO_SAT        = 16'hFFFF;
  localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT = 8'd100;
  localparam logic [LIMIT_W-1:0]  RST_UPPER_LIMIT  = 16'hFFFF;
  localparam logic [LIMIT_W-1:0]  RST_LOWER_LIMIT  = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_UPPER_LIMIT  = 2'd1,
    CFG_LOWER_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REF_GO,
    ST_REF_WAIT,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_RAT_GO,
    ST_RAT_WAIT,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/orwm_front.sv */
// ----------------------------------------------------------------------------
// orwm_front
// takes samples in scan order, accumulates per channel, hands off full blocks
// ----------------------------------------------------------------------------
module orwm_front #(
  parameter int CHANNELS = orwm_pkg::DEF_CHANNELS
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [orwm_pkg::SAMPLE_W-1:0]                 in_sample,
  input  logic [orwm_pkg::COUNT_W-1:0]                  count,
  input  orwm_pkg::q_status_t                           q_status,
  output logic                                          push,
  output logic [CHANNELS-1:0][orwm_pkg::SUM_W-1:0]      push_sums,
  output logic [orwm_pkg::COUNT_W-1:0]                  push_count
);
  import orwm_pkg::*;

  localparam int POS_W = $clog2(CHANNELS);

  logic [POS_W-1:0]                pos_r, pos_nxt;
  logic [COUNT_W-1:0]              scan_r, scan_nxt;
  logic [CHANNELS-1:0][SUM_W-1:0]  sums_r, sums_nxt;
  logic [COUNT_W-1:0]              scan_inc;
  logic [SUM_W-1:0]                new_sum;
  logic                            accept;
  logic                            last_pos;
  logic                            block_end;

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  assign last_pos  = (pos_r == POS_W'(CHANNELS - 1));
  assign scan_inc  = scan_r + COUNT_W'(1);
  assign block_end = accept && last_pos && ((scan_inc == '0) || (scan_inc >= count));

  // an over-range reading restarts the channel sum
  assign new_sum = (in_sample > SAMPLE_MAX) ? '0 : (sums_r[pos_r] + SUM_W'(in_sample));

  always_comb begin
    pos_nxt  = pos_r;
    scan_nxt = scan_r;
    sums_nxt = sums_r;
    if (accept) begin
      if (block_end) begin
        pos_nxt  = '0;
        scan_nxt = '0;
        sums_nxt = '0;
      end else if (last_pos) begin
        pos_nxt          = '0;
        scan_nxt         = scan_inc;
        sums_nxt[pos_r]  = new_sum;
      end else begin
        pos_nxt          = pos_r + POS_W'(1);
        sums_nxt[pos_r]  = new_sum;
      end
    end
  end

  // snapshot with the reference channel's final reading folded in
  always_comb begin
    push_sums                 = sums_r;
    push_sums[CHANNELS-1]     = new_sum;
  end

  assign push       = block_end;
  assign push_count = count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      scan_r <= '0;
      sums_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      scan_r <= scan_nxt;
      sums_r <= sums_nxt;
    end
  end

endmodule

/* hw/rtl/orwm_queue.sv */
// ----------------------------------------------------------------------------
// orwm_queue
// two-entry block queue between front and back
// ----------------------------------------------------------------------------
module orwm_queue #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output logic [W-1:0]        head_data,
  output orwm_pkg::q_status_t status
);
  import orwm_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [W-1:0]     entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign head_data    = entry_r[rd_ptr_r];
  assign status.full  = (fill_r == CNT_W'(Q_DEPTH));
  assign status.empty = (fill_r == '0);

endmodule

/* hw/rtl/orwm_div.sv */
// ----------------------------------------------------------------------------
// orwm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module orwm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  orwm_pkg::div_req_t req,
  output orwm_pkg::div_rsp_t rsp
);
  import orwm_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits carry it
      rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* hw/rtl/orwm_back.sv */
// ----------------------------------------------------------------------------
// orwm_back
// averages, ratios, window check and result register for one queued block
// ----------------------------------------------------------------------------
module orwm_back #(
  parameter int CHANNELS = orwm_pkg::DEF_CHANNELS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  orwm_pkg::q_status_t                               q_status,
  input  logic [CHANNELS-1:0][orwm_pkg::SUM_W-1:0]          head_sums,
  input  logic [orwm_pkg::COUNT_W-1:0]                      head_count,
  output logic                                              pop,
  input  logic [orwm_pkg::LIMIT_W-1:0]                      upper_limit,
  input  logic [orwm_pkg::LIMIT_W-1:0]                      lower_limit,
  output orwm_pkg::div_req_t                                div_req,
  input  orwm_pkg::div_rsp_t                                div_rsp,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [orwm_pkg::RATIO_OUTS-1:0][orwm_pkg::RATIO_W-1:0] out_ratio,
  output logic [orwm_pkg::FAULT_W-1:0]                      out_fault_word,
  output logic                                              out_reference_zero
);
  import orwm_pkg::*;

  localparam int NRATIO = (CHANNELS - 1 < RATIO_OUTS) ? CHANNELS - 1 : RATIO_OUTS;

  back_state_t state_r, state_nxt;

  logic [RIDX_W-1:0]                 k_r;
  logic [DVS_W-1:0]                  ref_avg_r;
  logic                              refzero_r;
  logic [DVD_W-1:0]                  mul_r;
  logic [RATIO_W-1:0]                ratio_r [RATIO_OUTS];
  logic [FAULT_W-1:0]                sticky_r, sticky_nxt;
  logic                              out_valid_r;
  logic [RATIO_OUTS-1:0][RATIO_W-1:0] out_ratio_r;
  logic [FAULT_W-1:0]                out_fault_r;
  logic                              out_refzero_r;
  logic [SUM_W-1:0]                  sel_sum [RATIO_OUTS];
  logic                              emit_go;
  logic                              last_k;
  logic                              hit;
  logic [RIDX_W-1:0]                 hit_k;

  // ratio channels that do not exist read as zero
  for (genvar i = 0; i < RATIO_OUTS; i++) begin : g_sel
    if (i < NRATIO) begin : g_on
      assign sel_sum[i] = head_sums[i];
    end else begin : g_off
      assign sel_sum[i] = '0;
    end
  end

  assign emit_go = !out_valid_r || out_ready;
  assign last_k  = (k_r == RIDX_W'(NRATIO - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (!q_status.empty) state_nxt = ST_REF_GO;
      ST_REF_GO:   state_nxt = ST_REF_WAIT;
      ST_REF_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (div_rsp.quotient == '0) ? ST_EMIT : ST_AVG_GO;
        end
      end
      ST_AVG_GO:   state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_rsp.done) state_nxt = ST_RAT_GO;
      ST_RAT_GO:   state_nxt = ST_RAT_WAIT;
      ST_RAT_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = last_k ? ST_EMIT : ST_AVG_GO;
        end
      end
      ST_EMIT:     if (emit_go) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs toward divider and queue
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DVS_W'(head_count);
    pop              = 1'b0;
    unique case (state_r)
      ST_REF_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(head_sums[CHANNELS-1]);
      end
      ST_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(sel_sum[k_r]);
      end
      ST_RAT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_r;
        div_req.divisor  = ref_avg_r;
      end
      ST_EMIT:  pop = emit_go;
      default:  ;
    endcase
  end

  // window check, first failing channel wins
  always_comb begin
    hit   = 1'b0;
    hit_k = '0;
    for (int i = 0; i < RATIO_OUTS; i++) begin
      if (!hit && (i < NRATIO) &&
          ((ratio_r[i] >= upper_limit) || (ratio_r[i] <= lower_limit))) begin
        hit   = 1'b1;
        hit_k = RIDX_W'(i);
      end
    end
    sticky_nxt = hit ? (sticky_r | FAULT_BASE | (FAULT_W'(1) << hit_k)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      sticky_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_EMIT) && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_REF_WAIT: if (div_rsp.done) k_r <= '0;
        ST_RAT_WAIT: if (div_rsp.done && !last_k) k_r <= k_r + RIDX_W'(1);
        ST_EMIT: begin
          if (emit_go) begin
            sticky_r <= sticky_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_REF_WAIT: begin
        if (div_rsp.done) begin
          ref_avg_r <= div_rsp.quotient[DVS_W-1:0];
          refzero_r <= (div_rsp.quotient == '0);
          for (int i = 0; i < RATIO_OUTS; i++) begin
            ratio_r[i] <= ((i < NRATIO) && (div_rsp.quotient == '0)) ? RATIO_SAT : '0;
          end
        end
      end
      ST_AVG_WAIT: if (div_rsp.done) mul_r <= div_rsp.quotient * SCALE;
      ST_RAT_WAIT: begin
        if (div_rsp.done) begin
          ratio_r[k_r] <= (div_rsp.quotient > DVD_W'(RATIO_SAT)) ? RATIO_SAT
                                                                 : div_rsp.quotient[RATIO_W-1:0];
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          for (int i = 0; i < RATIO_OUTS; i++) begin
            out_ratio_r[i] <= ratio_r[i];
          end
          out_fault_r   <= sticky_nxt;
          out_refzero_r <= refzero_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_ratio          = out_ratio_r;
  assign out_fault_word     = out_fault_r;
  assign out_reference_zero = out_refzero_r;

endmodule

/* hw/rtl/oversampled_ratio_window_monitor_unit.sv */
// ----------------------------------------------------------------------------
// oversampled_ratio_window_monitor_unit
// oversampled channel averages, ratios against a reference, sticky window faults
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in_     | in        | in_valid / in_ready  | in_sample, 16 bits
//   out_    | out       | out_valid / out_ready| out_ratio_0..4, out_fault_word,
//           |           |                      | out_reference_zero
//   cfg_    | in        | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// the front takes one sample word per cycle while the block queue has room
// each finished block costs the back 2*N+1 divisions on the shared one-bit-a-
// cycle divider (a single one when the reference average is zero), N being
// the number of ratio channels (5 at the default channel count)
// two finished blocks can wait in the queue; with both slots taken in_ready drops
// a result held in the output register does not stop the back from starting
// the next block; reset is synchronous, no clearing pass
//
module oversampled_ratio_window_monitor_unit #(
  parameter int CHANNELS = orwm_pkg::DEF_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [orwm_pkg::SAMPLE_W-1:0]    in_sample,
  // result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [orwm_pkg::RATIO_W-1:0]     out_ratio_0,
  output logic [orwm_pkg::RATIO_W-1:0]     out_ratio_1,
  output logic [orwm_pkg::RATIO_W-1:0]     out_ratio_2,
  output logic [orwm_pkg::RATIO_W-1:0]     out_ratio_3,
  output logic [orwm_pkg::RATIO_W-1:0]     out_ratio_4,
  output logic [orwm_pkg::FAULT_W-1:0]     out_fault_word,
  output logic                             out_reference_zero,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [orwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [orwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import orwm_pkg::*;

  localparam int ENTRY_W = CHANNELS * SUM_W + COUNT_W;

  // configuration registers
  logic [COUNT_W-1:0] sample_count_r;
  logic [LIMIT_W-1:0] upper_limit_r;
  logic [LIMIT_W-1:0] lower_limit_r;
  logic [COUNT_W-1:0] eff_count;

  // front to queue
  logic                           q_push;
  logic [CHANNELS-1:0][SUM_W-1:0] push_sums;
  logic [COUNT_W-1:0]             push_count;
  q_status_t                      q_status;

  // queue to back
  logic                           q_pop;
  logic [ENTRY_W-1:0]             head_data;
  logic [CHANNELS-1:0][SUM_W-1:0] head_sums;
  logic [COUNT_W-1:0]             head_count;

  // back to divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [RATIO_OUTS-1:0][RATIO_W-1:0] out_ratio;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= RST_SAMPLE_COUNT;
      upper_limit_r  <= RST_UPPER_LIMIT;
      lower_limit_r  <= RST_LOWER_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_UPPER_LIMIT:  upper_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_LOWER_LIMIT:  lower_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default:          ;
      endcase
    end
  end

  // a zero count behaves as a single scan
  assign eff_count = (sample_count_r == '0) ? COUNT_W'(1) : sample_count_r;

  orwm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .count      (eff_count),
    .q_status   (q_status),
    .push       (q_push),
    .push_sums  (push_sums),
    .push_count (push_count)
  );

  orwm_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_sums, push_count}),
    .pop       (q_pop),
    .head_data (head_data),
    .status    (q_status)
  );

  assign head_sums  = head_data[ENTRY_W-1:COUNT_W];
  assign head_count = head_data[COUNT_W-1:0];

  orwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  orwm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_status           (q_status),
    .head_sums          (head_sums),
    .head_count         (head_count),
    .pop                (q_pop),
    .upper_limit        (upper_limit_r),
    .lower_limit        (lower_limit_r),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ratio          (out_ratio),
    .out_fault_word     (out_fault_word),
    .out_reference_zero (out_reference_zero)
  );

  assign out_ratio_0 = out_ratio[0];
  assign out_ratio_1 = out_ratio[1];
  assign out_ratio_2 = out_ratio[2];
  assign out_ratio_3 = out_ratio[3];
  assign out_ratio_4 = out_ratio[4];

`ifndef SYNTHESIS
  // front never hands a block to a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("block pushed into full queue");

  // back only retires a block that is there
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("block popped from empty queue");

  // divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // any fault carries the base pattern
  a_fault_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault_word != '0)) |-> (out_fault_word[11:9] == 3'b111))
    else $error("fault word without base bits");

  // a zero reference saturates the first ratio
  a_refzero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reference_zero) |-> (out_ratio_0 == RATIO_SAT))
    else $error("zero reference without saturated ratio");
`endif

endmodule
